// ===== src/iirdf1_pkg.sv =====
// Package for the second-order direct-form-I IIR filter.
// Holds widths, register and tap codes, controller states and the
// command/status structs shared by the controller and the datapath.
package iirdf1_pkg;

  // Sample and coefficient formats: Q1.15 samples, Q4.14 coefficients
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int NUM_TAPS  = 5;
  // Five products of PROD_W bits need three guard bits
  localparam int ACC_W     = PROD_W + 3;
  localparam int TAP_W     = $clog2(NUM_TAPS);
  localparam int CNT_W     = $clog2(ACC_W);
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;

  // Default tap counts, fed to the top-level parameters
  localparam int FF_TAPS_DEF = 3;
  localparam int FB_TAPS_DEF = 3;

  // Reset values of the coefficient registers
  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(16384);
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

  // Saturation bounds
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF_COEF_0 = 3'd0,
    REG_FF_COEF_1 = 3'd1,
    REG_FF_COEF_2 = 3'd2,
    REG_FB_NORM   = 3'd3,
    REG_FB_COEF_1 = 3'd4,
    REG_FB_COEF_2 = 3'd5
  } cfg_reg_t;

  // Multiply-accumulate taps, in the order the controller walks them
  typedef enum logic [TAP_W-1:0] {
    TAP_X0 = 3'd0,
    TAP_X1 = 3'd1,
    TAP_X2 = 3'd2,
    TAP_Y1 = 3'd3,
    TAP_Y2 = 3'd4
  } tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic mul_en;
    tap_t mul_tap;
    logic acc_en;
    logic div_init;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_zero;
  } dp_status_t;

endpackage

// ===== src/iirdf1_in_if.sv =====
// Input sample channel of the IIR filter: valid/ready and one sample.
// Depends on iirdf1_pkg for the sample width.
interface iirdf1_in_if import iirdf1_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== src/iirdf1_out_if.sv =====
// Result channel of the IIR filter: valid/ready, filtered sample, error flag.
// Depends on iirdf1_pkg for the sample width.
interface iirdf1_out_if import iirdf1_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       norm_zero_error;

  modport source (output valid, output sample_out, output norm_zero_error, input ready);
  modport sink   (input valid, input sample_out, input norm_zero_error, output ready);
endinterface

// ===== src/iirdf1_ctrl.sv =====
// Controller of the IIR filter: sequences the multiply-accumulate taps and
// the serial division, and owns the channel handshakes. Uses iirdf1_pkg.
module iirdf1_ctrl
  import iirdf1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State, step counter and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.mul_tap   = TAP_X0;
    in_ready      = 1'b0;
    // drop the result once its transfer completes
    out_valid_nxt = out_valid_r & ~out_ready;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        // product of tap n is formed in step n and added in step n+1
        cmd.mul_en = (cnt_r < CNT_W'(NUM_TAPS));
        if (cmd.mul_en) begin
          cmd.mul_tap = tap_t'(cnt_r[TAP_W-1:0]);
        end
        cmd.acc_en = (cnt_r != '0);
        if (cnt_r == CNT_W'(NUM_TAPS)) begin
          state_nxt = status.norm_zero ? ST_FINISH : ST_DIV_INIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/iirdf1_dp.sv =====
// Datapath of the IIR filter: coefficient registers, sample histories,
// shared multiplier and accumulator, restoring divider and saturation.
// Uses iirdf1_pkg; driven by commands from iirdf1_ctrl.
module iirdf1_dp
  import iirdf1_pkg::*;
#(
  parameter int FF_TAPS = FF_TAPS_DEF,
  parameter int FB_TAPS = FB_TAPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [SAMPLE_W-1:0]   sample_in,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  output logic signed [SAMPLE_W-1:0]   sample_out,
  output logic                         norm_zero_error
);

  logic signed [COEF_W-1:0]   ff0_r, ff1_r, ff2_r, norm_r, fb1_r, fb2_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] x1_r, x2_r, y1_r, y2_r;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic                       prod_sub_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]           quo_r;
  logic [COEF_W-1:0]          rem_r, rem_nxt;
  logic [COEF_W-1:0]          dsr_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] out_r;
  logic                       err_r;

  logic signed [SAMPLE_W-1:0] op_x;
  logic signed [COEF_W-1:0]   op_c;
  logic                       op_sub;
  logic signed [ACC_W-1:0]    prod_ext;
  logic [ACC_W-1:0]           acc_mag;
  logic [COEF_W-1:0]          norm_mag;
  logic [COEF_W:0]            trial;
  logic                       trial_ge;
  logic                       pos_ovf, neg_ovf;
  logic signed [SAMPLE_W-1:0] result;

  // Coefficient registers, to be written only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff0_r  <= COEF_ONE;
      ff1_r  <= COEF_ZERO;
      ff2_r  <= COEF_ZERO;
      norm_r <= COEF_ONE;
      fb1_r  <= COEF_ZERO;
      fb2_r  <= COEF_ZERO;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FF_COEF_0: ff0_r  <= cfg_data;
        REG_FF_COEF_1: ff1_r  <= cfg_data;
        REG_FF_COEF_2: ff2_r  <= cfg_data;
        REG_FB_NORM:   norm_r <= cfg_data;
        REG_FB_COEF_1: fb1_r  <= cfg_data;
        REG_FB_COEF_2: fb2_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign status.norm_zero = (norm_r == COEF_ZERO);

  // Select the operands of the current tap; taps left out read as zero
  always_comb begin
    op_x   = sample_r;
    op_c   = ff0_r;
    op_sub = 1'b0;
    case (cmd.mul_tap)
      TAP_X0: begin
        op_x = sample_r;
        op_c = ff0_r;
      end
      TAP_X1: begin
        op_x = x1_r;
        op_c = (FF_TAPS > 1) ? ff1_r : COEF_ZERO;
      end
      TAP_X2: begin
        op_x = x2_r;
        op_c = (FF_TAPS > 2) ? ff2_r : COEF_ZERO;
      end
      TAP_Y1: begin
        op_x   = y1_r;
        op_c   = (FB_TAPS > 1) ? fb1_r : COEF_ZERO;
        op_sub = 1'b1;
      end
      TAP_Y2: begin
        op_x   = y2_r;
        op_c   = (FB_TAPS > 2) ? fb2_r : COEF_ZERO;
        op_sub = 1'b1;
      end
      default: begin
        op_x = sample_r;
        op_c = COEF_ZERO;
      end
    endcase
  end

  assign prod_nxt = op_x * op_c;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Multiplier output register and accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sample_r <= sample_in;
      acc_r    <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= prod_sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
    if (cmd.mul_en) begin
      prod_r     <= prod_nxt;
      prod_sub_r <= op_sub;
    end
  end

  // Magnitudes for the divider
  assign acc_mag  = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign norm_mag = norm_r[COEF_W-1] ? (~norm_r + 1'b1) : norm_r;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem_r, quo_r[ACC_W-1]};
  assign trial_ge = (trial >= {1'b0, dsr_r});
  assign rem_nxt  = trial_ge ? COEF_W'(trial - {1'b0, dsr_r}) : trial[COEF_W-1:0];

  // Divider registers; the dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= acc_mag;
      rem_r <= '0;
      dsr_r <= norm_mag;
      neg_r <= acc_r[ACC_W-1] ^ norm_r[COEF_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[ACC_W-2:0], trial_ge};
      rem_r <= rem_nxt;
    end
  end

  // Saturate the signed quotient to the sample range
  assign pos_ovf = |quo_r[ACC_W-1:SAMPLE_W-1];
  assign neg_ovf = (|quo_r[ACC_W-1:SAMPLE_W]) ||
                   (quo_r[SAMPLE_W-1] && (|quo_r[SAMPLE_W-2:0]));

  always_comb begin
    if (status.norm_zero) begin
      result = '0;
    end else if (neg_r) begin
      result = neg_ovf ? SAMPLE_MIN : (~quo_r[SAMPLE_W-1:0] + 1'b1);
    end else begin
      result = pos_ovf ? SAMPLE_MAX : quo_r[SAMPLE_W-1:0];
    end
  end

  // Sample histories advance once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (cmd.finish) begin
      x1_r <= sample_r;
      x2_r <= x1_r;
      y1_r <= result;
      y2_r <= y1_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= result;
      err_r <= status.norm_zero;
    end
  end

  assign sample_out      = out_r;
  assign norm_zero_error = err_r;

endmodule

// ===== src/iir_filter_direct_form_one.sv =====
// Second-order direct-form-I IIR filter, Q1.15 samples and Q4.14
// coefficients. Each accepted sample passes, from its transfer to its result
// sitting in the output register, through the five taps on the single
// shared 16x18 multiplier and its accumulator, a step to set up the divider,
// the restoring divider (one quotient bit per cycle over the 37-bit
// accumulator) and a step to saturate and load the output register. When
// fb_norm is zero the division is skipped and the result appears with
// norm_zero_error set and sample_out zero. One sample is in work at a
// time; the next is taken in the cycle after the previous result is loaded,
// whether or not that result has been transferred. A finished sample waits
// while an earlier result is still stalled in the output register.
// The user must write coefficients through the cfg port only while the
// filter is idle; the block itself does not enforce this.
module iir_filter_direct_form_one
  import iirdf1_pkg::*;
#(
  parameter int FEEDFORWARD_TAPS = FF_TAPS_DEF,
  parameter int FEEDBACK_TAPS    = FB_TAPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  iirdf1_in_if.sink             in_chan,
  iirdf1_out_if.source          out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer and handshakes
  iirdf1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and storage
  iirdf1_dp #(
    .FF_TAPS (FEEDFORWARD_TAPS),
    .FB_TAPS (FEEDBACK_TAPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_in       (in_chan.sample_in),
    .cmd             (cmd),
    .status          (status),
    .sample_out      (out_chan.sample_out),
    .norm_zero_error (out_chan.norm_zero_error)
  );

endmodule

// ===== src/iirdf1_checker.sv =====
// Port-level checker for the IIR filter, with its bind to the top level.
// Depends on iirdf1_pkg and the iir_filter_direct_form_one port list.
module iirdf1_port_checker
  import iirdf1_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic                       norm_zero_error
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(norm_zero_error))
    else $error("result changed while stalled");

  // One sample in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in work");

  // No result can be produced straight after a transfer in
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Finishing a sample frees the input side
  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("input not ready when result appeared");

  // A zero divisor forces a zero sample
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && norm_zero_error |-> sample_out == '0)
    else $error("nonzero sample with divisor error");

endmodule

bind iir_filter_direct_form_one iirdf1_port_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .sample_out      (out_chan.sample_out),
  .norm_zero_error (out_chan.norm_zero_error)
);
